/* hw/rtl/pm_sensor_frame_receiver_top_assert.svh */
// Assertion macros for the particulate sensor frame receiver.
`ifndef PM_SENSOR_FRAME_RECEIVER_TOP_ASSERT_SVH
`define PM_SENSOR_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PMSFR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pmsfr: same-cycle check failed");
`define PMSFR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pmsfr: next-cycle check failed");
`else
`define PMSFR_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define PMSFR_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

/* hw/rtl/pmsfr_pkg.sv */
// Package: constants and types of the particulate sensor frame receiver.
`timescale 1ns / 1ps
package pmsfr_pkg;

  localparam int FRAME_LEN  = 32;
  localparam int POS_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int NUM_READ   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int READ_FIRST = 4;

  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'h44;
  localparam logic [WORD_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [POS_W-1:0] POS_SUM_END = POS_W'(FRAME_LEN - 2);

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = CFG_IDX_W'(1);

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SUM_ERR = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_READ-1:0] reading_t;

  typedef struct packed {
    logic     fire;
    status_t  status;
    reading_t value;
  } evt_t;

  typedef struct packed {
    reading_t lo;
    reading_t hi;
  } stats_t;

  typedef struct packed {
    status_t  status;
    reading_t value;
    stats_t   stats;
  } result_t;

endpackage

/* hw/rtl/pmsfr_if.sv */
// Channel interfaces: input items, results and register writes.
`timescale 1ns / 1ps
interface pmsfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface pmsfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pm1_value;
  logic [15:0] pm25_value;
  logic [15:0] pm10_value;
  logic [15:0] pm1_min;
  logic [15:0] pm1_max;
  logic [15:0] pm25_min;
  logic [15:0] pm25_max;
  logic [15:0] pm10_min;
  logic [15:0] pm10_max;
  modport source (output valid, output status, output pm1_value, output pm25_value,
                  output pm10_value, output pm1_min, output pm1_max, output pm25_min,
                  output pm25_max, output pm10_min, output pm10_max, input ready);
  modport sink (input valid, input status, input pm1_value, input pm25_value,
                input pm10_value, input pm1_min, input pm1_max, input pm25_min,
                input pm25_max, input pm10_min, input pm10_max, output ready);
endinterface

interface pmsfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/pm_sensor_frame_receiver_top.sv */
// Top level of the particulate sensor frame receiver.
`timescale 1ns / 1ps
// Takes one received byte or time tick per transaction and reports a result
// at the end of each frame (valid readings, checksum mismatch) or when an
// inter-byte timeout abandons a partial frame; all other bytes and ticks give
// no result. One transaction is taken every clock cycle while no result waits
// unread; a result that waits stalls the input. The input register loads at
// the accepting edge; the result register, the frame state and the min/max
// registers load when it advances. Register writes take effect at once and
// are always accepted.
`include "pm_sensor_frame_receiver_top_assert.svh"
module pm_sensor_frame_receiver_top (
  input logic         clk,
  input logic         rst,
  pmsfr_in_if.sink    item,
  pmsfr_out_if.source result,
  pmsfr_cfg_if.sink   cfg
);
  import pmsfr_pkg::*;

  logic [BYTE_W-1:0] header_value;
  logic [WORD_W-1:0] timeout_limit;

  logic              stage_valid;
  logic              stage_req_type;
  logic [BYTE_W-1:0] stage_rx_byte;
  logic              advance;

  evt_t              evt;
  stats_t            stats_next;
  logic              res_valid;
  result_t           res_q;
  logic              res_ok;
  logic              res_in_range;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value  <= HEADER_RESET;
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HEADER_VALUE:  header_value  <= cfg.data[BYTE_W-1:0];
        CFG_TIMEOUT_LIMIT: timeout_limit <= cfg.data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = stage_valid && (!res_valid || result.ready);
  assign item.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_req_type <= item.req_type;
      stage_rx_byte  <= item.rx_byte;
    end
  end

  pmsfr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .req_type      (stage_req_type),
    .rx_byte       (stage_rx_byte),
    .header_value  (header_value),
    .timeout_limit (timeout_limit),
    .evt           (evt)
  );

  pmsfr_minmax u_minmax (
    .clk        (clk),
    .rst        (rst),
    .upd        (advance && evt.fire && evt.status == STATUS_OK),
    .value      (evt.value),
    .stats_next (stats_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= evt.fire;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.fire) begin
      res_q.status <= evt.status;
      res_q.value  <= evt.value;
      res_q.stats  <= stats_next;
    end
  end

  assign result.valid      = res_valid;
  assign result.status     = res_q.status;
  assign result.pm1_value  = res_q.value[0];
  assign result.pm25_value = res_q.value[1];
  assign result.pm10_value = res_q.value[2];
  assign result.pm1_min    = res_q.stats.lo[0];
  assign result.pm1_max    = res_q.stats.hi[0];
  assign result.pm25_min   = res_q.stats.lo[1];
  assign result.pm25_max   = res_q.stats.hi[1];
  assign result.pm10_min   = res_q.stats.lo[2];
  assign result.pm10_max   = res_q.stats.hi[2];

  assign res_ok       = res_valid && res_q.status == STATUS_OK;
  assign res_in_range = res_q.stats.lo[0] <= res_q.value[0] &&
                        res_q.value[0] <= res_q.stats.hi[0] &&
                        res_q.stats.lo[1] <= res_q.value[1] &&
                        res_q.value[1] <= res_q.stats.hi[1] &&
                        res_q.stats.lo[2] <= res_q.value[2] &&
                        res_q.value[2] <= res_q.stats.hi[2];

  `PMSFR_ASSERT_IMP(a_err_no_reading, clk, rst, res_valid && !res_ok, res_q.value == '0)
  `PMSFR_ASSERT_IMP(a_ok_in_range, clk, rst, res_ok, res_in_range)
  `PMSFR_ASSERT_NXT(a_fire_shows, clk, rst, advance && evt.fire, res_valid)

endmodule

/* hw/rtl/pmsfr_parser.sv */
// Frame parser: header hunt, byte count, checksum, reading capture, timeout.
`timescale 1ns / 1ps
module pmsfr_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic                                 req_type,
  input  logic [pmsfr_pkg::BYTE_W-1:0]         rx_byte,
  input  logic [pmsfr_pkg::BYTE_W-1:0]         header_value,
  input  logic [pmsfr_pkg::WORD_W-1:0]         timeout_limit,
  output pmsfr_pkg::evt_t                      evt
);
  import pmsfr_pkg::*;

  typedef enum logic [1:0] {
    ST_HUNT  = 2'b01,
    ST_FRAME = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [POS_W-1:0]    pos, pos_next;
  word_t               sum, sum_next;
  logic [BYTE_W-1:0]   trailer, trailer_next;
  word_t               idle, idle_next;
  reading_t            cap, cap_next;
  logic [WORD_W:0]     idle_inc;

  assign idle_inc = {1'b0, idle} + (WORD_W+1)'(1);

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    sum_next     = sum;
    trailer_next = trailer;
    idle_next    = idle;
    cap_next     = cap;
    evt          = '0;
    unique case (state)
      ST_HUNT: begin
        if (req_type == REQ_BYTE && rx_byte == header_value) begin
          state_next = ST_FRAME;
          pos_next   = POS_W'(1);
          sum_next   = {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
          idle_next  = '0;
        end
      end
      ST_FRAME: begin
        if (req_type == REQ_TICK) begin
          if (idle_inc >= {1'b0, timeout_limit}) begin
            state_next   = ST_HUNT;
            pos_next     = '0;
            sum_next     = '0;
            trailer_next = '0;
            idle_next    = '0;
            evt.fire     = 1'b1;
            evt.status   = STATUS_TIMEOUT;
          end else begin
            idle_next = idle_inc[WORD_W-1:0];
          end
        end else begin
          idle_next = '0;
          if (pos < POS_SUM_END) begin
            sum_next = sum + {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
            for (int k = 0; k < NUM_READ; k++) begin
              if (pos == POS_W'(READ_FIRST + 2*k))
                cap_next[k][WORD_W-1:BYTE_W] = rx_byte;
              if (pos == POS_W'(READ_FIRST + 2*k + 1))
                cap_next[k][BYTE_W-1:0] = rx_byte;
            end
            pos_next = pos + POS_W'(1);
          end else if (pos == POS_SUM_END) begin
            trailer_next = rx_byte;
            pos_next     = pos + POS_W'(1);
          end else begin
            state_next   = ST_HUNT;
            pos_next     = '0;
            sum_next     = '0;
            trailer_next = '0;
            evt.fire     = 1'b1;
            if (sum == {trailer, rx_byte}) begin
              evt.status = STATUS_OK;
              evt.value  = cap;
            end else begin
              evt.status = STATUS_SUM_ERR;
            end
          end
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_HUNT;
      pos     <= '0;
      sum     <= '0;
      trailer <= '0;
      idle    <= '0;
      cap     <= '0;
    end else if (step) begin
      state   <= state_next;
      pos     <= pos_next;
      sum     <= sum_next;
      trailer <= trailer_next;
      idle    <= idle_next;
      cap     <= cap_next;
    end
  end

endmodule

/* hw/rtl/pmsfr_minmax.sv */
// Running minimum and maximum of the three readings over valid frames.
`timescale 1ns / 1ps
module pmsfr_minmax (
  input  logic                clk,
  input  logic                rst,
  input  logic                upd,
  input  pmsfr_pkg::reading_t value,
  output pmsfr_pkg::stats_t   stats_next
);
  import pmsfr_pkg::*;

  stats_t stats;
  logic   seen;

  always_comb begin
    stats_next = stats;
    if (upd) begin
      for (int k = 0; k < NUM_READ; k++) begin
        if (!seen) begin
          stats_next.lo[k] = value[k];
          stats_next.hi[k] = value[k];
        end else begin
          if (value[k] > stats.hi[k]) stats_next.hi[k] = value[k];
          if (value[k] < stats.lo[k]) stats_next.lo[k] = value[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats.lo <= '1;
      stats.hi <= '0;
      seen     <= 1'b0;
    end else begin
      stats <= stats_next;
      if (upd) seen <= 1'b1;
    end
  end

endmodule
